/* rtl/mmad_pkg.sv */
// ----------------------------------------------------------------------------
// mmad_pkg
// Shared types and constants of the memory map address decoder: request and
// response words, configuration image, register indexes and route codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mmad_pkg;

   localparam int unsigned REGIONS    = 4;
   localparam int unsigned HW_REGIONS = 4;

   localparam int unsigned ADDR_WIDTH      = 32;
   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned BITS_WIDTH      = 6;
   localparam int unsigned BOUNDS_WIDTH    = 64;
   localparam int unsigned KIND_WIDTH      = 2;
   localparam int unsigned KINDS_WIDTH     = KIND_WIDTH * HW_REGIONS;
   localparam int unsigned REGION_WIDTH    = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = BOUNDS_WIDTH;

   localparam logic [ADDR_WIDTH-1:0] FULL_MASK  = 32'hFFFF_FFFF;
   localparam logic [BYTE_WIDTH-1:0] OPEN_BUS   = 8'hFF;
   localparam logic [BITS_WIDTH-1:0] WIDTH_FULL = 6'd32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADDRESS_BITS   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION0_BOUNDS = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION1_BOUNDS = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION2_BOUNDS = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION3_BOUNDS = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION_KINDS   = 3'd5;

   localparam logic [KIND_WIDTH-1:0] ROUTE_UNMAPPED = 2'd0;
   localparam logic [KIND_WIDTH-1:0] ROUTE_RAM      = 2'd1;
   localparam logic [KIND_WIDTH-1:0] ROUTE_ROM      = 2'd2;
   localparam logic [KIND_WIDTH-1:0] ROUTE_MMIO     = 2'd3;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic                  command;
      logic [ADDR_WIDTH-1:0] address;
      logic [BYTE_WIDTH-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]   route;
      logic [REGION_WIDTH-1:0] region;
      logic [ADDR_WIDTH-1:0]   offset;
      logic [ADDR_WIDTH-1:0]   masked_address;
      logic                    do_write;
      logic                    dropped;
      logic [BYTE_WIDTH-1:0]   data;
   } rsp_word_type;

   typedef struct packed {
      logic [BITS_WIDTH-1:0]                     bus_bits;
      logic [HW_REGIONS-1:0][BOUNDS_WIDTH-1:0]   bounds;
      logic [KINDS_WIDTH-1:0]                    kinds;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/mmad_decode.sv */
// ----------------------------------------------------------------------------
// mmad_decode
// Combinational decode of one bus word: address mask, region pick by greatest
// start, bounds check, offset and write/drop flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mmad_decode (
   input  var mmad_pkg::cfg_type      cfg,
   input  var mmad_pkg::req_word_type word,
   output mmad_pkg::rsp_word_type     rsp
);

   logic [mmad_pkg::ADDR_WIDTH-1:0] mask;
   logic [mmad_pkg::ADDR_WIDTH-1:0] addr;

   always_comb begin
      if (cfg.bus_bits == '0 || cfg.bus_bits >= mmad_pkg::WIDTH_FULL) begin
         mask = mmad_pkg::FULL_MASK;
      end else begin
         mask = ~(mmad_pkg::FULL_MASK << cfg.bus_bits[4:0]);
      end
   end

   assign addr = word.address & mask;

   always_comb begin
      logic                              found;
      logic [mmad_pkg::REGION_WIDTH-1:0] best;
      logic [mmad_pkg::ADDR_WIDTH-1:0]   best_start;
      logic [mmad_pkg::ADDR_WIDTH-1:0]   start;
      logic [mmad_pkg::ADDR_WIDTH-1:0]   stop;
      logic [mmad_pkg::KIND_WIDTH-1:0]   kind;
      logic [mmad_pkg::KIND_WIDTH-1:0]   route;
      logic                              is_write;

      found      = 1'b0;
      best       = '0;
      best_start = '0;
      for (int i = 0; i < int'(mmad_pkg::REGIONS); i++) begin
         kind  = cfg.kinds[i*mmad_pkg::KIND_WIDTH +: mmad_pkg::KIND_WIDTH];
         start = cfg.bounds[i][mmad_pkg::BOUNDS_WIDTH-1:mmad_pkg::ADDR_WIDTH];
         if (kind != mmad_pkg::ROUTE_UNMAPPED && start <= addr
               && (!found || start >= best_start)) begin
            found      = 1'b1;
            best       = mmad_pkg::REGION_WIDTH'(i);
            best_start = start;
         end
      end

      stop     = cfg.bounds[best][mmad_pkg::ADDR_WIDTH-1:0];
      is_write = (word.command == mmad_pkg::CMD_WRITE);

      rsp = '0;
      rsp.masked_address = addr;
      if (found && addr <= stop) begin
         route      = cfg.kinds[best*mmad_pkg::KIND_WIDTH +: mmad_pkg::KIND_WIDTH];
         rsp.region = best;
         rsp.offset = addr - best_start;
      end else begin
         route = mmad_pkg::ROUTE_UNMAPPED;
      end
      rsp.route = route;

      if (is_write) begin
         rsp.data = word.value;
      end else if (route == mmad_pkg::ROUTE_UNMAPPED) begin
         rsp.data = mmad_pkg::OPEN_BUS;
      end else begin
         rsp.data = '0;
      end

      rsp.do_write = is_write
         && (route == mmad_pkg::ROUTE_RAM || route == mmad_pkg::ROUTE_MMIO);
      rsp.dropped  = is_write
         && (route == mmad_pkg::ROUTE_UNMAPPED || route == mmad_pkg::ROUTE_ROM);
   end

endmodule

`default_nettype wire

/* rtl/memory_map_address_decoder.sv */
// ----------------------------------------------------------------------------
// memory_map_address_decoder
// Routes single-byte bus accesses to RAM, ROM or MMIO regions.
//
// Request words (command, address, value) enter on req_valid/req_stall; one
// response word (route, region, offset, masked address, write/drop flags,
// data) leaves on rsp_valid/rsp_stall for every request, in order.
// A word moves when valid is high and stall is low at a rising clock edge.
// A request is held in the input register, decoded combinationally and
// stored in the response register. Throughput: one word per cycle when
// not stalled; the region compare is fully parallel over the four windows.
// When rsp_stall is high the response holds; the input register keeps
// taking words until it is full, and req_stall stays high while it is full.
// Reset (synchronous, active high) empties both registers and clears all
// CSRs: address width 0 (full 32-bit mask) and every region disabled.
// The user must write CSRs through csr_wr_en/csr_index/csr_wdata only while
// the block is idle (not enforced); indexes above region kinds are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_map_address_decoder (
   input  var logic                                   clock,
   input  var logic                                   reset,
   input  var logic                                   req_valid,
   output logic                                       req_stall,
   input  var mmad_pkg::req_word_type                 req_word,
   output logic                                       rsp_valid,
   input  var logic                                   rsp_stall,
   output mmad_pkg::rsp_word_type                     rsp_word,
   input  var logic                                   csr_wr_en,
   input  var logic [mmad_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  var logic [mmad_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   mmad_pkg::cfg_type      cfg_ff;
   mmad_pkg::cfg_type      cfg_in;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   mmad_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   mmad_pkg::rsp_word_type out_word_ff;
   mmad_pkg::rsp_word_type decoded;
   logic                   out_load;
   logic                   in_load;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mmad_pkg::CSR_ADDRESS_BITS:
               cfg_in.bus_bits = csr_wdata[mmad_pkg::BITS_WIDTH-1:0];
            mmad_pkg::CSR_REGION0_BOUNDS: cfg_in.bounds[0] = csr_wdata;
            mmad_pkg::CSR_REGION1_BOUNDS: cfg_in.bounds[1] = csr_wdata;
            mmad_pkg::CSR_REGION2_BOUNDS: cfg_in.bounds[2] = csr_wdata;
            mmad_pkg::CSR_REGION3_BOUNDS: cfg_in.bounds[3] = csr_wdata;
            mmad_pkg::CSR_REGION_KINDS:
               cfg_in.kinds = csr_wdata[mmad_pkg::KINDS_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   mmad_decode u_decode (
      .cfg  (cfg_ff),
      .word (in_word_ff),
      .rsp  (decoded)
   );

   assign out_load     = !out_valid_ff || !rsp_stall;
   assign in_load      = !in_valid_ff || out_load;
   assign req_stall    = !in_load;
   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_word_ff <= req_word;
      end
      if (out_load && in_valid_ff) begin
         out_word_ff <= decoded;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

`default_nettype wire

/* rtl/mmad_checker.sv */
// ----------------------------------------------------------------------------
// mmad_checker
// Port-level checks of the memory map address decoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mmad_checker (
   input  var logic                   clock,
   input  var logic                   reset,
   input  var logic                   rsp_valid,
   input  var logic                   rsp_stall,
   input  var mmad_pkg::rsp_word_type rsp_word
);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   a_unmapped_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.route == mmad_pkg::ROUTE_UNMAPPED
         |-> rsp_word.region == '0 && rsp_word.offset == '0)
      else $error("unmapped word carries region or offset");

   a_write_flags : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.do_write && rsp_word.dropped)
         && (rsp_word.do_write == (rsp_word.route == mmad_pkg::ROUTE_RAM
            || rsp_word.route == mmad_pkg::ROUTE_MMIO) || rsp_word.dropped
            || !rsp_word.do_write))
      else $error("write performed and dropped at once");

   a_open_bus : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.do_write && !rsp_word.dropped
         && rsp_word.route == mmad_pkg::ROUTE_UNMAPPED
         |-> rsp_word.data == mmad_pkg::OPEN_BUS)
      else $error("unmapped read does not return open bus");

endmodule

bind memory_map_address_decoder mmad_checker u_checker (.*);

`default_nettype wire

/* tb/sv/memory_map_address_decoder_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memory_map_address_decoder_check
// Passive checker for the address decoder. It follows CSR writes to keep its
// own copy of the width mask and the four windows, and decodes every request
// word taken by the block. Response words are matched in order against those
// decodes, field by field. It reports the mismatch count and the number of
// decodes still waiting for a response word.
// ----------------------------------------------------------------------------
module memory_map_address_decoder_check (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  mmad_pkg::req_word_type                req_word,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  mmad_pkg::rsp_word_type                rsp_word,
   input  logic                                  csr_wr_en,
   input  logic [mmad_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mmad_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output int unsigned                           mismatches,
   output int unsigned                           outstanding
);
   import mmad_pkg::*;

   logic [BITS_WIDTH-1:0]                   width_bits;
   logic [HW_REGIONS-1:0][BOUNDS_WIDTH-1:0] window_bounds;
   logic [KINDS_WIDTH-1:0]                  window_kinds;
   rsp_word_type                            predicted_decodes[$];
   int unsigned                             mismatch_count = 0;

   assign mismatches = mismatch_count;

   function automatic rsp_word_type decode_access(req_word_type access);
      logic [ADDR_WIDTH-1:0]   mask;
      logic [ADDR_WIDTH-1:0]   addr;
      logic [ADDR_WIDTH-1:0]   start;
      logic [ADDR_WIDTH-1:0]   best_start;
      logic [KIND_WIDTH-1:0]   kind;
      logic [REGION_WIDTH-1:0] best;
      logic                    found;
      int                      slot;
      rsp_word_type            decode;
      if (width_bits == '0 || width_bits >= WIDTH_FULL) begin
         mask = FULL_MASK;
      end else begin
         mask = (32'd1 << width_bits) - 32'd1;
      end
      addr       = access.address & mask;
      found      = 1'b0;
      best       = '0;
      best_start = '0;
      for (slot = 0; slot < REGIONS && slot < HW_REGIONS; slot++) begin
         kind  = window_kinds[KIND_WIDTH*slot +: KIND_WIDTH];
         start = window_bounds[slot][BOUNDS_WIDTH-1 -: ADDR_WIDTH];
         // highest start not above the address; later index wins a tie
         if (kind != ROUTE_UNMAPPED && start <= addr && (!found || start >= best_start)) begin
            found      = 1'b1;
            best       = slot[REGION_WIDTH-1:0];
            best_start = start;
         end
      end
      decode = '0;
      decode.masked_address = addr;
      if (found && addr <= window_bounds[best][ADDR_WIDTH-1:0]) begin
         decode.route  = window_kinds[KIND_WIDTH*best +: KIND_WIDTH];
         decode.region = best;
         decode.offset = addr - best_start;
      end
      if (access.command == CMD_WRITE) begin
         decode.data     = access.value;
         decode.do_write = (decode.route == ROUTE_RAM || decode.route == ROUTE_MMIO);
         decode.dropped  = (decode.route == ROUTE_UNMAPPED || decode.route == ROUTE_ROM);
      end else if (decode.route == ROUTE_UNMAPPED) begin
         decode.data = OPEN_BUS;
      end
      return decode;
   endfunction

   task automatic compare_field(string label, logic [ADDR_WIDTH-1:0] want,
                                logic [ADDR_WIDTH-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         width_bits    <= '0;
         window_bounds <= '0;
         window_kinds  <= '0;
         predicted_decodes.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index) inside
               CSR_ADDRESS_BITS: width_bits <= csr_wdata[BITS_WIDTH-1:0];
               CSR_REGION0_BOUNDS, CSR_REGION1_BOUNDS, CSR_REGION2_BOUNDS,
               CSR_REGION3_BOUNDS: window_bounds[csr_index - CSR_REGION0_BOUNDS] <= csr_wdata;
               CSR_REGION_KINDS: window_kinds <= csr_wdata[KINDS_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted_decodes.push_back(decode_access(req_word));
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_decodes.size() == 0) begin
               mismatch_count++;
               $display("%0t: response word 0x%0h with no request pending", $time, rsp_word);
            end else begin
               want = predicted_decodes.pop_front();
               compare_field("route", want.route, rsp_word.route);
               compare_field("region", want.region, rsp_word.region);
               compare_field("offset", want.offset, rsp_word.offset);
               compare_field("masked_address", want.masked_address, rsp_word.masked_address);
               compare_field("do_write", want.do_write, rsp_word.do_write);
               compare_field("dropped", want.dropped, rsp_word.dropped);
               compare_field("data", want.data, rsp_word.data);
            end
         end
      end
      outstanding <= predicted_decodes.size();
   end

endmodule

/* tb/sv/memory_map_address_decoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memory_map_address_decoder_test
// Top of the address decoder bench. Loads a series of region maps over the
// CSR port - hand-built ones for shadowing, inverted windows, equal starts
// and the width extremes, then random clustered maps - and sends byte
// accesses aimed at window edges, plus random noise, with random gaps on
// the request side and random stalls on the response side. The checker
// beside the block does all comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module memory_map_address_decoder_test;
   import mmad_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 3'd7;
   localparam int RANDOM_MAPS  = 8;
   localparam int MAP_ACCESSES = 150;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_word_type               req_word;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_word_type               rsp_word;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   int unsigned                mismatches;
   int unsigned                outstanding;
   bit                         sender_gaps     = 1'b0;
   bit                         receiver_stalls = 1'b0;
   cfg_type                    region_map;

   memory_map_address_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   memory_map_address_decoder_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("memory_map_address_decoder_test: FAIL");
      $finish;
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [ADDR_WIDTH-1:0] span_mask(logic [BITS_WIDTH-1:0] bits);
      if (bits == '0 || bits >= WIDTH_FULL) return FULL_MASK;
      return (32'd1 << bits) - 32'd1;
   endfunction

   function automatic logic [ADDR_WIDTH-1:0] pick_address();
      logic [ADDR_WIDTH-1:0] mask;
      logic [ADDR_WIDTH-1:0] start;
      logic [ADDR_WIDTH-1:0] stop;
      logic [ADDR_WIDTH-1:0] near;
      int unsigned           slot;
      mask  = span_mask(region_map.bus_bits);
      slot  = $urandom_range(0, HW_REGIONS - 1);
      start = region_map.bounds[slot][BOUNDS_WIDTH-1 -: ADDR_WIDTH];
      stop  = region_map.bounds[slot][ADDR_WIDTH-1:0];
      case ($urandom_range(0, 9))
         0: near = start - 32'd1;
         1: near = start;
         2: near = stop;
         3: near = stop + 32'd1;
         4, 5, 6: near = start + $urandom_range(0, 4095);
         7: near = stop - $urandom_range(0, 255);
         default: return $urandom();
      endcase
      if ($urandom_range(0, 1) == 0) return near;
      // spill random bits above the bus width
      return (near & mask) | ($urandom() & ~mask);
   endfunction

   function automatic cfg_type random_map();
      cfg_type               m;
      logic [ADDR_WIDTH-1:0] mask;
      logic [ADDR_WIDTH-1:0] cluster;
      logic [ADDR_WIDTH-1:0] start;
      logic [ADDR_WIDTH-1:0] stop;
      m = '0;
      case ($urandom_range(0, 5))
         0: m.bus_bits = '0;
         1: m.bus_bits = BITS_WIDTH'($urandom_range(32, 63));
         2: m.bus_bits = BITS_WIDTH'($urandom_range(1, 31));
         default: m.bus_bits = BITS_WIDTH'($urandom_range(12, 20));
      endcase
      mask    = span_mask(m.bus_bits);
      cluster = $urandom() & mask;
      for (int i = 0; i < HW_REGIONS; i++) begin
         if (i > 0 && $urandom_range(0, 4) == 0) begin
            start = m.bounds[i-1][BOUNDS_WIDTH-1 -: ADDR_WIDTH];
         end else begin
            start = (cluster + $urandom_range(0, 8191)) & mask;
         end
         case ($urandom_range(0, 7))
            0: stop = start - $urandom_range(1, 64);
            1: stop = start;
            2: stop = $urandom();
            default: stop = start + $urandom_range(0, 4095);
         endcase
         m.bounds[i] = {start, stop};
      end
      m.kinds = KINDS_WIDTH'($urandom());
      return m;
   endfunction

   task automatic set_window(int unsigned slot, logic [ADDR_WIDTH-1:0] start,
                             logic [ADDR_WIDTH-1:0] stop, logic [KIND_WIDTH-1:0] kind);
      region_map.bounds[slot] = {start, stop};
      region_map.kinds[KIND_WIDTH*slot +: KIND_WIDTH] = kind;
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] reg_index,
                            logic [CSR_DATA_WIDTH-1:0] reg_value);
      csr_wr_en <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= reg_value;
      @(posedge clock);
   endtask

   task automatic load_map(cfg_type m);
      logic [CSR_DATA_WIDTH-1:0] csr_value;
      csr_value = {$urandom(), $urandom()};
      csr_value[BITS_WIDTH-1:0] = m.bus_bits;
      write_csr(CSR_ADDRESS_BITS, csr_value);
      for (int i = 0; i < HW_REGIONS; i++) begin
         write_csr(CSR_INDEX_WIDTH'(CSR_REGION0_BOUNDS + i), m.bounds[i]);
      end
      csr_value = {$urandom(), $urandom()};
      csr_value[KINDS_WIDTH-1:0] = m.kinds;
      write_csr(CSR_REGION_KINDS, csr_value);
      write_csr(CSR_SPARE_LOW, {$urandom(), $urandom()});
      write_csr(CSR_SPARE_HIGH, {$urandom(), $urandom()});
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_access(logic command, logic [ADDR_WIDTH-1:0] address,
                              logic [BYTE_WIDTH-1:0] value);
      req_word_type access;
      access.command = command;
      access.address = address;
      access.value   = value;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= access;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // everything disabled out of reset
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      send_access(CMD_READ, 32'h0000_0000, 8'h00);
      send_access(CMD_WRITE, 32'hFFFF_FFFF, 8'hFF);
      send_access(CMD_READ, 32'h8000_0001, 8'h5A);
      drain_responses();

      // inverted window shadowing RAM, window past its end
      region_map = '0;
      region_map.bus_bits = '0;
      set_window(0, 32'h0000_0000, 32'h0000_FFFF, ROUTE_RAM);
      set_window(1, 32'h0001_0000, 32'h0001_FFFF, ROUTE_ROM);
      set_window(2, 32'h8000_0000, 32'hFFFF_FFFF, ROUTE_MMIO);
      set_window(3, 32'h0000_8000, 32'h0000_7FFF, ROUTE_ROM);
      load_map(region_map);
      send_access(CMD_READ, 32'h0000_0000, 8'h00);
      send_access(CMD_WRITE, 32'h0000_7FFF, 8'h81);
      send_access(CMD_READ, 32'h0000_8000, 8'h00);
      send_access(CMD_WRITE, 32'h0001_0000, 8'h3C);
      send_access(CMD_READ, 32'h0001_FFFF, 8'hFF);
      send_access(CMD_READ, 32'h0002_0000, 8'h00);
      send_access(CMD_WRITE, 32'h8000_0000, 8'hFF);
      send_access(CMD_WRITE, 32'hFFFF_FFFF, 8'h00);
      send_access(CMD_READ, 32'hFFFF_FFFF, 8'h00);
      send_access(CMD_WRITE, 32'h7FFF_FFFF, 8'hA5);
      drain_responses();

      // equal starts, a disabled window, 16-bit bus
      region_map = '0;
      region_map.bus_bits = 6'd16;
      set_window(0, 32'h0000_1000, 32'h0000_1FFF, ROUTE_RAM);
      set_window(1, 32'h0000_1000, 32'h0000_10FF, ROUTE_MMIO);
      set_window(2, 32'h0000_1000, 32'hFFFF_FFFF, ROUTE_UNMAPPED);
      set_window(3, 32'h0000_0000, 32'h0000_0FFF, ROUTE_ROM);
      load_map(region_map);
      send_access(CMD_READ, 32'hABCD_1050, 8'h00);
      send_access(CMD_WRITE, 32'h0000_1100, 8'h42);
      send_access(CMD_WRITE, 32'hFFFF_0FFF, 8'h99);
      send_access(CMD_READ, 32'hFFFF_FFFF, 8'h00);
      drain_responses();

      // 1-bit bus, all bounds zero, all MMIO
      region_map = '0;
      region_map.bus_bits = 6'd1;
      region_map.kinds = '1;
      load_map(region_map);
      send_access(CMD_WRITE, 32'hFFFF_FFFE, 8'h01);
      send_access(CMD_READ, 32'hFFFF_FFFF, 8'h00);
      drain_responses();

      // widest width code, all bounds at the top
      region_map = '1;
      load_map(region_map);
      send_access(CMD_READ, 32'hFFFF_FFFF, 8'h00);
      send_access(CMD_WRITE, 32'hFFFF_FFFE, 8'h7E);
      drain_responses();

      // 31-bit bus, RAM over the whole space
      region_map = '0;
      region_map.bus_bits = 6'd31;
      set_window(0, 32'h0000_0000, 32'h7FFF_FFFF, ROUTE_RAM);
      load_map(region_map);
      send_access(CMD_READ, 32'hFFFF_FFFF, 8'h00);
      send_access(CMD_WRITE, 32'h8000_0000, 8'hC3);
      drain_responses();

      for (int p = 0; p < RANDOM_MAPS; p++) begin
         region_map = random_map();
         if (p == 0) region_map.bus_bits = WIDTH_FULL;
         sender_gaps     = (p % 4 == 0) || (p % 4 == 1);
         receiver_stalls = (p % 4 == 0) || (p % 4 == 2);
         load_map(region_map);
         for (int n = 0; n < MAP_ACCESSES; n++) begin
            // hold off until the pipe is empty
            if (p == 1 && n == MAP_ACCESSES / 2) drain_responses();
            send_access(1'($urandom_range(0, 1)), pick_address(),
                        BYTE_WIDTH'($urandom()));
         end
         drain_responses();
      end

      repeat (4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("memory_map_address_decoder_test: PASS");
      end else begin
         $display("memory_map_address_decoder_test: FAIL");
      end
      $finish;
   end

endmodule
